@@ rtl/plc_pkg.sv @@
// ---------------------------------------------------------------------------
// plc_pkg: shared types and codes for the positional list store
// Request kinds, result status codes and the per-cell operation struct.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

    localparam int VALUE_W = 32;

    // Request kinds.
    localparam logic [1:0] KIND_FIND   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_DELETE = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BADPOS   = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_op_t;

endpackage

`default_nettype wire

@@ rtl/plc_cell.sv @@
// ---------------------------------------------------------------------------
// plc_cell: one slot of the list
// Holds one entry, takes its left or right neighbor on a shift or the new value
// on an insert at its own index, and compares its entry against the search value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_cell
    import plc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
)
(
    input  wire logic                         clk,
    input  wire cell_op_t                     op,
    input  wire logic [$clog2(DEPTH)-1:0]     op_pos,
    input  wire logic [VALUE_W-1:0]           ins_value,
    input  wire logic [VALUE_W-1:0]           left_entry,
    input  wire logic [VALUE_W-1:0]           right_entry,
    input  wire logic [$clog2(DEPTH+1)-1:0]   count,
    input  wire logic [VALUE_W-1:0]           cmp_value,
    output logic      [VALUE_W-1:0]           entry,
    output logic                              match
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] MY_IDX = IW'(IDX);
    localparam logic [CW-1:0] MY_CNT = CW'(IDX);

    logic [VALUE_W-1:0] entry_reg;
    logic [VALUE_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins && (MY_IDX > op_pos))
        begin
            entry_next = left_entry;
        end
        else if (op.ins && (MY_IDX == op_pos))
        begin
            entry_next = ins_value;
        end
        else if (op.del && (MY_IDX >= op_pos))
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    // Only slots below the fill count hold list entries.
    assign match = (MY_CNT < count) && (entry_reg == cmp_value);

endmodule

`default_nettype wire

@@ rtl/plc_scan.sv @@
// ---------------------------------------------------------------------------
// plc_scan: first-match search over the cell match bits
// Walks the match vector eight cells per cycle and stops at the first hit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module plc_scan
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [DEPTH-1:0]           match,
    output logic                            busy,
    output logic                            done,
    output logic                            hit,
    output logic [$clog2(DEPTH)-1:0]        idx
);

    localparam int G  = 8;
    localparam int NG = (DEPTH + G - 1) / G;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int IW = $clog2(DEPTH);

    logic          busy_reg;
    logic [GW-1:0] grp_reg;
    logic [NG*G-1:0] padded;
    logic [G-1:0]    grp_bits;
    logic [2:0]      enc;
    logic            last;

    assign padded   = (NG*G)'(match);
    assign grp_bits = padded[grp_reg*G +: G];
    assign last     = (grp_reg == GW'(NG - 1));

    // Lowest set bit of the current group wins.
    always_comb
    begin
        hit = 1'b0;
        enc = 3'd0;
        for (int k = G - 1; k >= 0; k--)
        begin
            if (grp_bits[k])
            begin
                hit = 1'b1;
                enc = 3'(k);
            end
        end
    end

    assign busy = busy_reg;
    assign done = busy_reg && (hit || last);
    assign idx  = hit ? IW'({grp_reg, enc}) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            grp_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            grp_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            grp_reg <= grp_reg + 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/positional_list_store.sv @@
// ---------------------------------------------------------------------------
// positional_list_store: packed ordered list with find, insert and delete
// A row of DEPTH cells holds the list; shifts happen in all cells at once.
// ---------------------------------------------------------------------------
// Usage:
// A request word (kind, value, position) is taken on the input channel when
// in_valid is high and in_stall is low. Each request gives exactly one result
// word (status, found_index, count) on the output channel, taken when
// out_valid is high and out_stall is low.
// Insert, delete and the unused kind finish in the accepting cycle; the result
// goes to the output register, or to the skid slot while the output is held,
// and the next request can be taken in the next cycle unless the skid is full.
// Find registers the search value, every cell compares it against its entry
// at once, and the first-match scan walks the match bits eight cells per
// cycle up to the group holding the first hit, or the last group when nothing
// matches; the result is then registered like any other, and the input stalls
// until the scan ends.
// An output register plus one skid slot let a request be accepted while the
// previous result waits; with both full, in_stall holds the input.
// Reset empties the list; no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module positional_list_store
    import plc_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [1:0]                     kind,
    input  wire logic signed [VALUE_W-1:0]      value,
    input  wire logic [$clog2(DEPTH+2)-1:0]     position,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [1:0]                          status,
    output logic [$clog2(DEPTH)-1:0]            found_index,
    output logic [$clog2(DEPTH+1)-1:0]          count
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = $clog2(DEPTH + 2);

    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [VALUE_W-1:0] value_reg;

    logic               out_valid_reg;
    logic [1:0]         status_reg;
    logic [IW-1:0]      found_reg;
    logic [CW-1:0]      count_out_reg;
    logic               skid_valid_reg;
    logic [1:0]         skid_status_reg;
    logic [IW-1:0]      skid_found_reg;
    logic [CW-1:0]      skid_count_reg;

    logic               accept;
    logic               res_valid;
    logic [1:0]         res_status;
    logic [IW-1:0]      res_idx;
    cell_op_t           op;
    logic [IW-1:0]      op_pos;
    logic [PW:0]        pos_ext;
    logic [PW:0]        cnt_ext;

    logic               scan_start;
    logic               scan_busy;
    logic               scan_done;
    logic               scan_hit;
    logic [IW-1:0]      scan_idx;

    logic [VALUE_W-1:0] cell_entry [DEPTH];
    logic [DEPTH-1:0]   cell_match;

    assign in_stall = scan_busy || skid_valid_reg;
    assign accept   = in_valid && !in_stall;

    assign pos_ext = {1'b0, position};
    assign cnt_ext = (PW+1)'(count_reg);
    assign op_pos  = IW'(position - 1'b1);

    always_comb
    begin
        op         = '0;
        count_next = count_reg;
        scan_start = 1'b0;
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_idx    = '0;
        if (accept)
        begin
            case (kind)
                KIND_FIND:
                begin
                    scan_start = 1'b1;
                end
                KIND_INSERT:
                begin
                    res_valid = 1'b1;
                    // The full check comes before the position check.
                    if (count_reg == CW'(DEPTH))
                    begin
                        res_status = ST_FULL;
                    end
                    else if ((position == '0) || (pos_ext > cnt_ext + 1'b1))
                    begin
                        res_status = ST_BADPOS;
                    end
                    else
                    begin
                        op.ins     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    res_valid = 1'b1;
                    if ((position == '0) || (pos_ext > cnt_ext))
                    begin
                        res_status = ST_BADPOS;
                    end
                    else
                    begin
                        op.del     = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    res_valid = 1'b1;
                end
            endcase
        end
        else if (scan_done)
        begin
            res_valid  = 1'b1;
            res_status = scan_hit ? ST_OK : ST_NOTFOUND;
            res_idx    = scan_idx;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [VALUE_W-1:0] left_e;
            logic [VALUE_W-1:0] right_e;

            if (gi == 0)
            begin : g_first
                assign left_e = $unsigned(value);
            end
            else
            begin : g_mid_l
                assign left_e = cell_entry[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[gi];
            end
            else
            begin : g_mid_r
                assign right_e = cell_entry[gi+1];
            end

            plc_cell #(
                .DEPTH (DEPTH),
                .IDX   (gi)
            ) u_cell (
                .clk         (clk),
                .op          (op),
                .op_pos      (op_pos),
                .ins_value   ($unsigned(value)),
                .left_entry  (left_e),
                .right_entry (right_e),
                .count       (count_reg),
                .cmp_value   (value_reg),
                .entry       (cell_entry[gi]),
                .match       (cell_match[gi])
            );
        end
    endgenerate

    plc_scan #(
        .DEPTH (DEPTH)
    ) u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_start),
        .match (cell_match),
        .busy  (scan_busy),
        .done  (scan_done),
        .hit   (scan_hit),
        .idx   (scan_idx)
    );

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            value_reg <= $unsigned(value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (!out_valid_reg || !out_stall)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg   <= 1'b1;
                    status_reg      <= skid_status_reg;
                    found_reg       <= skid_found_reg;
                    count_out_reg   <= skid_count_reg;
                    skid_valid_reg  <= res_valid;
                    skid_status_reg <= res_status;
                    skid_found_reg  <= res_idx;
                    skid_count_reg  <= count_next;
                end
                else
                begin
                    out_valid_reg <= res_valid;
                    status_reg    <= res_status;
                    found_reg     <= res_idx;
                    count_out_reg <= count_next;
                end
            end
            else if (res_valid)
            begin
                // The output word is held; park the new result one slot back.
                skid_valid_reg  <= 1'b1;
                skid_status_reg <= res_status;
                skid_found_reg  <= res_idx;
                skid_count_reg  <= count_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found_index = found_reg;
    assign count       = count_out_reg;

endmodule

`default_nettype wire

@@ tb/positional_list_store_tb.sv @@
// ---------------------------------------------------------------------------
// positional_list_store_tb: self-checking bench for the positional list store
// Drives find, insert, delete and unused-kind words with bursty traffic and a
// randomly stalling receiver, keeps its own copy of the list to predict every
// reply, and compares each reply word field by field in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_store_tb;
    import plc_pkg::*;

    localparam int DEPTH       = 16;
    localparam int POS_W       = $clog2(DEPTH + 2);
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT = 200000;

    // The block answers the fourth request kind with OK and leaves the list as it is.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] entries;
    } list_reply_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              kind = KIND_FIND;
    logic signed [31:0]      value = '0;
    logic [POS_W-1:0]        position = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic [IDX_W-1:0]        found_index;
    logic [CNT_W-1:0]        count;

    // Predicted list contents and length.
    logic [31:0]             list_mem [DEPTH];
    int                      list_len = 0;
    list_reply_t             pending_replies [$];

    int  errors = 0;
    int  cycle_count = 0;
    int  burst_left = 0;
    bit  hold_req = 1'b0;
    int  n_find = 0, n_hit = 0, n_insert = 0, n_delete = 0, n_full = 0, n_badpos = 0;

    positional_list_store #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .value(value),
        .position(position),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .found_index(found_index),
        .count(count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", CYCLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Applies one accepted request to the list copy and returns the reply.
    function automatic list_reply_t apply_request(input logic [1:0] k, input logic [31:0] v,
                                                  input logic [POS_W-1:0] p);
        list_reply_t r;
        int          j;
        bit          hit;
        r.status = ST_OK;
        r.index  = '0;
        hit      = 1'b0;
        case (k)
            KIND_FIND:
            begin
                n_find++;
                for (j = 0; j < list_len; j++)
                begin
                    if (!hit && list_mem[IDX_W'(j)] == v)
                    begin
                        hit     = 1'b1;
                        r.index = j[IDX_W-1:0];
                    end
                end
                if (hit)
                    n_hit++;
                else
                    r.status = ST_NOTFOUND;
            end
            KIND_INSERT:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                    n_full++;
                end
                else if (p < 1 || int'(p) > list_len + 1)
                begin
                    r.status = ST_BADPOS;
                    n_badpos++;
                end
                else
                begin
                    for (j = list_len; j >= int'(p); j--)
                        list_mem[IDX_W'(j)] = list_mem[IDX_W'(j-1)];
                    list_mem[IDX_W'(p-1)] = v;
                    list_len++;
                    n_insert++;
                end
            end
            KIND_DELETE:
            begin
                if (p < 1 || int'(p) > list_len)
                begin
                    r.status = ST_BADPOS;
                    n_badpos++;
                end
                else
                begin
                    for (j = int'(p); j < list_len; j++)
                        list_mem[IDX_W'(j-1)] = list_mem[IDX_W'(j)];
                    list_len--;
                    n_delete++;
                end
            end
            default:
            begin
            end
        endcase
        r.entries = list_len[CNT_W-1:0];
        return r;
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_word(input logic [1:0] k, input logic [31:0] v,
                             input logic [POS_W-1:0] p);
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(apply_request(k, v, p));
    endtask

    task automatic pace_sender();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
            burst_left = $urandom_range(24, 0);
        end
    endtask

    task automatic wait_for_replies();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    // Favors values already stored so that finds hit and duplicates arise.
    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40 && list_len > 0)
            return list_mem[IDX_W'($urandom_range(list_len - 1))];
        if (roll < 55)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (roll < 75)
            return $urandom_range(7);
        return $urandom;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : check_replies
        list_reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word, expected none, got status %0d count %0d",
                         $time, status, count);
            end
            else
            begin
                want = pending_replies.pop_front();
                check_field("status", int'(want.status), int'(status));
                check_field("found_index", int'(want.index), int'(found_index));
                check_field("count", int'(want.entries), int'(count));
            end
        end
    end

    // Receiver: stretches with their own stall rate, plus a long hold on request.
    initial
    begin : receiver
        int stretch;
        int pct;
        @(posedge rst_n);
        forever
        begin
            stretch = $urandom_range(40, 4);
            case ($urandom_range(3))
                0: pct = 0;
                1: pct = 25;
                2: pct = 50;
                default: pct = 80;
            endcase
            repeat (stretch)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    hold_req = 1'b0;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                out_stall <= ($urandom_range(99) < pct);
            end
        end
    end

    task automatic test_empty_list();
        send_word(KIND_FIND, 32'h0, POS_W'(1));
        pace_sender();
        send_word(KIND_DELETE, 32'h0, POS_W'(1));
        pace_sender();
        send_word(KIND_DELETE, 32'h0, '0);
        pace_sender();
        send_word(KIND_INSERT, 32'h5, '0);
        pace_sender();
        send_word(KIND_INSERT, 32'h5, '1);
        pace_sender();
        send_word(KIND_UNUSED, 32'hFFFF_FFFF, '1);
        pace_sender();
    endtask

    task automatic test_fill_to_full();
        logic [31:0]      v;
        logic [POS_W-1:0] p;
        for (int i = 0; i < DEPTH; i++)
        begin
            case (i)
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                3: v = 32'hFFFF_FFFF;
                default: v = 32'(i % 4);
            endcase
            case (i % 3)
                0: p = POS_W'(1);
                1: p = POS_W'(list_len + 1);
                default: p = POS_W'(list_len / 2 + 1);
            endcase
            send_word(KIND_INSERT, v, p);
            pace_sender();
            if (i == 5)
            begin
                // A position two past the end is rejected on a non-empty list.
                send_word(KIND_INSERT, 32'h1234_5678, POS_W'(list_len + 2));
                pace_sender();
            end
        end
        send_word(KIND_FIND, 32'h7FFF_FFFF, '0);
        send_word(KIND_FIND, 32'h2, '0);
        // The full check wins over a bad position.
        send_word(KIND_INSERT, 32'h9, '0);
        send_word(KIND_INSERT, 32'h9, POS_W'(1));
        send_word(KIND_DELETE, 32'h0, POS_W'(DEPTH + 1));
        send_word(KIND_DELETE, 32'h0, POS_W'(DEPTH));
        send_word(KIND_DELETE, 32'h0, POS_W'(1));
        pace_sender();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int i = 0; i < 24; i++)
            send_word((i % 3 == 0) ? KIND_FIND : KIND_INSERT, pick_value(),
                      POS_W'($urandom_range(list_len + 1, 1)));
        wait_for_replies();
    endtask

    task automatic test_random_traffic(input int n_items);
        logic [1:0]       k;
        logic [31:0]      v;
        logic [POS_W-1:0] p;
        int               grow_pct;
        int               roll;
        grow_pct = 70;
        for (int i = 0; i < n_items; i++)
        begin
            // Swing between growing and shrinking so the list hits full and empty.
            if (i % 40 == 0)
                grow_pct = $urandom_range(85, 15);
            roll = $urandom_range(99);
            v = pick_value();
            if (roll < 8)
            begin
                k = 2'($urandom_range(3));
                p = POS_W'($urandom_range(2**POS_W - 1));
            end
            else if (roll < 35)
            begin
                k = KIND_FIND;
                p = POS_W'($urandom_range(2**POS_W - 1));
            end
            else if ($urandom_range(99) < grow_pct)
            begin
                k = KIND_INSERT;
                p = POS_W'($urandom_range(list_len + 1, 1));
            end
            else
            begin
                k = KIND_DELETE;
                p = (list_len == 0) ? POS_W'(1) : POS_W'($urandom_range(list_len, 1));
            end
            send_word(k, v, p);
            pace_sender();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_fill_to_full();
        test_backpressure();
        test_random_traffic(400);
        test_random_traffic(320);
        wait_for_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_replies.size() != 0)
        begin
            errors++;
            $display("%0t: %0d replies never arrived", $time, pending_replies.size());
        end
        $display("Run covered %0d finds (%0d hits), %0d inserts, %0d deletes,", n_find,
                 n_hit, n_insert, n_delete);
        $display("%0d list-full and %0d bad-position replies, %0d mismatches.", n_full,
                 n_badpos, errors);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
